// ----- design/box_qp_two_by_two_solver_assert.svh -----
// Assertion macros for the 2x2 box QP solver checker
`ifndef BOX_QP_TWO_BY_TWO_SOLVER_ASSERT_SVH
`define BOX_QP_TWO_BY_TWO_SOLVER_ASSERT_SVH
// implication checked every clock outside reset
`define BQP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bqp check failed");
// next-cycle implication
`define BQP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bqp check failed");
`endif

// ----- design/bqp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqp_pkg
// Shared types and constants of the 2x2 box QP solver.
// ---------------------------------------------------------------------------
package bqp_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  // wide work words: products of three data words plus scale and margin
  localparam int WideWidth = 3 * DataWidth + FracBits + 8;
  localparam int QuotWidth = WideWidth;
  localparam int AddrWidth = 3;

  localparam logic [AddrWidth-1:0] REG_LOWER = 3'd0;
  localparam logic [AddrWidth-1:0] REG_UPPER = 3'd4;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [WideWidth-1:0] wide_t;

  typedef enum logic [3:0] {
    CASE_FREE = 4'd0, CASE_LL = 4'd1, CASE_IL = 4'd2, CASE_UL = 4'd3,
    CASE_LI = 4'd4, CASE_II = 4'd5, CASE_UI = 4'd6, CASE_LU = 4'd7,
    CASE_IU = 4'd8, CASE_UU = 4'd9
  } case_t;

  // classified word: result known except the two quotients
  typedef struct packed {
    wide_t num1;
    wide_t den1;
    wide_t num2;
    wide_t den2;
    logic  div1;     // first value comes from a quotient
    logic  div2;
    data_t fix1;     // bound value when not a quotient
    data_t fix2;
    case_t code;
    logic  singular;
  } job_t;
endpackage

// ----- design/bqp_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqp_front
// Pipelined front end: products, determinant and box case selection.
// ---------------------------------------------------------------------------
module bqp_front import bqp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  logic  in_valid,
  input  data_t a11_in,
  input  data_t a22_in,
  input  data_t a12_in,
  input  data_t b1_in,
  input  data_t b2_in,
  input  data_t lower,
  input  data_t upper,
  output logic  job_valid,
  output job_t  job
);
  // stage 1: products of data words
  logic  v1;
  wide_t p_a11a22, p_a12a12, p_a22b1, p_a12b2, p_a11b2, p_a12b1;
  wide_t p_a11l, p_a11u, p_a12l, p_a12u, p_a22l, p_a22u;
  wide_t s_b1, s_b2;
  data_t l1, u1;
  logic  box1;

  // exact 32x32 signed product, sign-extended to the wide word
  function automatic wide_t mulw(input data_t x, input data_t y);
    logic signed [2*DataWidth-1:0] p;
    p = x * y;
    mulw = WideWidth'(p);
  endfunction

  function automatic wide_t ext(input data_t x);
    ext = WideWidth'(x);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (advance) v1 <= in_valid;
    if (advance) begin
      p_a11a22 <= mulw(a11_in, a22_in);
      p_a12a12 <= mulw(a12_in, a12_in);
      p_a22b1  <= mulw(a22_in, b1_in);
      p_a12b2  <= mulw(a12_in, b2_in);
      p_a11b2  <= mulw(a11_in, b2_in);
      p_a12b1  <= mulw(a12_in, b1_in);
      p_a11l   <= mulw(a11_in, lower);
      p_a11u   <= mulw(a11_in, upper);
      p_a12l   <= mulw(a12_in, lower);
      p_a12u   <= mulw(a12_in, upper);
      p_a22l   <= mulw(a22_in, lower);
      p_a22u   <= mulw(a22_in, upper);
      s_b1     <= ext(b1_in) <<< FracBits;
      s_b2     <= ext(b2_in) <<< FracBits;
      l1       <= lower;
      u1       <= upper;
      box1     <= lower < upper;
    end
  end

  // stage 2: determinant, Cramer numerators and boundary sums
  logic  v2;
  wide_t det, m1, m2, sl, su, tl, tu, p1ul, p1lu, p2ul, p2lu, b1s, b2s;
  wide_t r1l, r1u, r2l, r2u;
  data_t l2, u2;
  logic  box2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (advance) v2 <= v1;
    if (advance) begin
      det  <= p_a11a22 - p_a12a12;
      m1   <= (p_a22b1 - p_a12b2) <<< FracBits;
      m2   <= (p_a11b2 - p_a12b1) <<< FracBits;
      sl   <= p_a11l + p_a12l;
      su   <= p_a11u + p_a12u;
      tl   <= p_a12l + p_a22l;
      tu   <= p_a12u + p_a22u;
      p1ul <= p_a11u + p_a12l;
      p1lu <= p_a11l + p_a12u;
      p2ul <= p_a12u + p_a22l;
      p2lu <= p_a12l + p_a22u;
      r1l  <= s_b1 - p_a12l;
      r1u  <= s_b1 - p_a12u;
      r2l  <= s_b2 - p_a12l;
      r2u  <= s_b2 - p_a12u;
      b1s  <= s_b1;
      b2s  <= s_b2;
      l2   <= l1;
      u2   <= u1;
      box2 <= box1;
    end
  end

  // stage 3: det times bounds, split into low and high halves of det
  // (det fits 2*DataWidth+1 bits, so each half product is about 32x32)
  logic  v3;
  logic signed [2*DataWidth:0] dl_lo, dl_hi, du_lo, du_hi;
  wide_t dl, du;
  wide_t det3, m13, m23, sl3, su3, tl3, tu3, p1ul3, p1lu3, p2ul3, p2lu3;
  wide_t b13, b23, r1l3, r1u3, r2l3, r2u3;
  data_t l3, u3;
  logic  box3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (advance) v3 <= v2;
    if (advance) begin
      dl_lo <= $signed({1'b0, det[DataWidth-1:0]}) * l2;
      dl_hi <= $signed(det[2*DataWidth:DataWidth]) * l2;
      du_lo <= $signed({1'b0, det[DataWidth-1:0]}) * u2;
      du_hi <= $signed(det[2*DataWidth:DataWidth]) * u2;
      det3  <= det;  m13 <= m1;  m23 <= m2;
      sl3   <= sl;   su3 <= su;  tl3 <= tl;  tu3 <= tu;
      p1ul3 <= p1ul; p1lu3 <= p1lu; p2ul3 <= p2ul; p2lu3 <= p2lu;
      b13   <= b1s;  b23 <= b2s;
      r1l3  <= r1l;  r1u3 <= r1u; r2l3 <= r2l; r2u3 <= r2u;
      l3    <= l2;   u3 <= u2;  box3 <= box2;
    end
  end

  // recombine the half products
  assign dl = (WideWidth'(dl_hi) <<< DataWidth) + WideWidth'(dl_lo);
  assign du = (WideWidth'(du_hi) <<< DataWidth) + WideWidth'(du_lo);

  // diagonal entries for the one-coordinate divisors: delay the raw words
  data_t a11_d1, a11_d2, a22_d1, a22_d2;
  always_ff @(posedge clk) begin
    if (advance) begin
      a11_d1 <= a11_in; a11_d2 <= a11_d1;
      a22_d1 <= a22_in; a22_d2 <= a22_d1;
    end
  end
  data_t a11_d3, a22_d3;
  always_ff @(posedge clk) begin
    if (advance) begin
      a11_d3 <= a11_d2;
      a22_d3 <= a22_d2;
    end
  end

  // stage 4: case selection in the fixed test order
  job_t pick;
  always_comb begin
    pick = '0;
    pick.fix1 = l3;
    pick.fix2 = l3;
    pick.code = CASE_FREE;
    pick.num1 = m13; pick.den1 = det3; pick.num2 = m23; pick.den2 = det3;
    if (det3 == '0) begin
      pick.singular = 1'b1;
      pick.fix1 = '0;
      pick.fix2 = '0;
    end else if (!box3) begin
      pick.div1 = 1'b1;
      pick.div2 = 1'b1;
    end else if (b13 <= sl3 && b23 <= tl3) begin
      pick.code = CASE_LL;
    end else if (sl3 < b13 && b13 < p1ul3 && m23 <= dl) begin
      pick.code = CASE_IL;
      pick.div1 = 1'b1; pick.num1 = r1l3; pick.den1 = ext(a11_d3);
    end else if (p1ul3 <= b13 && b23 <= p2ul3) begin
      pick.code = CASE_UL; pick.fix1 = u3;
    end else if (b13 <= p1lu3 && p2lu3 <= b23) begin
      pick.code = CASE_LU; pick.fix2 = u3;
    end else if (su3 <= b13 && tu3 <= b23) begin
      pick.code = CASE_UU; pick.fix1 = u3; pick.fix2 = u3;
    end else if (p1lu3 < b13 && b13 < su3 && du <= m23) begin
      pick.code = CASE_IU; pick.fix2 = u3;
      pick.div1 = 1'b1; pick.num1 = r1u3; pick.den1 = ext(a11_d3);
    end else if (tl3 < b23 && b23 < p2lu3 && m13 <= dl) begin
      pick.code = CASE_LI;
      pick.div2 = 1'b1; pick.num2 = r2l3; pick.den2 = ext(a22_d3);
    end else if (p2ul3 < b23 && b23 < tu3 && du <= m13) begin
      pick.code = CASE_UI; pick.fix1 = u3;
      pick.div2 = 1'b1; pick.num2 = r2u3; pick.den2 = ext(a22_d3);
    end else begin
      pick.code = CASE_II;
      pick.div1 = 1'b1;
      pick.div2 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) job_valid <= 1'b0;
    else if (advance) job_valid <= v3;
    if (advance) job <= pick;
  end
endmodule

// ----- design/bqp_divider.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqp_divider
// Fully pipelined restoring signed divider, one quotient bit per stage,
// with saturation to the data range.
// ---------------------------------------------------------------------------
module bqp_divider import bqp_pkg::*; (
  input  logic   clk,
  input  logic   advance,
  input  logic   enable,
  input  wide_t  num,
  input  wide_t  den,
  output data_t  quotient,
  output logic   clipped
);
  typedef logic [QuotWidth-1:0] mag_t;

  mag_t rem   [QuotWidth+1];
  mag_t nreg  [QuotWidth+1];
  mag_t dreg  [QuotWidth+1];
  mag_t qreg  [QuotWidth+1];
  logic neg   [QuotWidth+1];
  logic zer   [QuotWidth+1];
  logic en    [QuotWidth+1];

  // entry stage: magnitudes and sign
  always_comb begin
    nreg[0] = num[WideWidth-1] ? mag_t'(-num) : mag_t'(num);
    dreg[0] = den[WideWidth-1] ? mag_t'(-den) : mag_t'(den);
    rem[0]  = '0;
    qreg[0] = '0;
    neg[0]  = num[WideWidth-1] ^ den[WideWidth-1];
    zer[0]  = den == '0;
    en[0]   = enable;
  end

  // one registered step per quotient bit, most significant first
  for (genvar s = 0; s < QuotWidth; s++) begin : g_step
    logic [QuotWidth:0] trial;
    assign trial = {rem[s], nreg[s][QuotWidth-1-s]} - {1'b0, dreg[s]};
    always_ff @(posedge clk) begin
      if (advance) begin
        if (!trial[QuotWidth]) begin
          rem[s+1]  <= trial[QuotWidth-1:0];
          qreg[s+1] <= qreg[s] | (mag_t'(1) << (QuotWidth-1-s));
        end else begin
          rem[s+1]  <= {rem[s][QuotWidth-2:0], nreg[s][QuotWidth-1-s]};
          qreg[s+1] <= qreg[s];
        end
        nreg[s+1] <= nreg[s];
        dreg[s+1] <= dreg[s];
        neg[s+1]  <= neg[s];
        zer[s+1]  <= zer[s];
        en[s+1]   <= en[s];
      end
    end
  end

  // sign and saturation
  localparam mag_t MaxPos = mag_t'({1'b0, {(DataWidth-1){1'b1}}});
  logic  q_neg, q_en, q_zero;
  mag_t  q_mag;
  assign q_neg  = neg[QuotWidth];
  assign q_en   = en[QuotWidth];
  assign q_zero = zer[QuotWidth];
  assign q_mag  = qreg[QuotWidth];
  always_comb begin
    quotient = '0;
    clipped  = 1'b0;
    if (q_en && !q_zero) begin
      if (q_neg) begin
        if (q_mag > MaxPos + mag_t'(1)) begin
          clipped = 1'b1;
          quotient = {1'b1, {(DataWidth-1){1'b0}}};
        end else quotient = data_t'(-q_mag);
      end else begin
        if (q_mag > MaxPos) begin
          clipped = 1'b1;
          quotient = {1'b0, {(DataWidth-1){1'b1}}};
        end else quotient = data_t'(q_mag);
      end
    end
  end
  logic unused_rem;
  assign unused_rem = ^rem[QuotWidth] ^ ^nreg[QuotWidth] ^ ^dreg[QuotWidth];
endmodule

// ----- design/bqp_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqp_back
// Back end: two pipelined dividers and the output register.
// ---------------------------------------------------------------------------
module bqp_back import bqp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  job_valid,
  input  job_t  job,
  output logic  job_stall,
  output logic  out_valid,
  input  logic  out_stall,
  output data_t first_value,
  output data_t second_value,
  output logic [3:0] case_code,
  output logic  singular,
  output logic  saturated
);
  localparam int Depth = QuotWidth;
  logic advance;
  // pipeline moves unless a finished word is stuck in the output register
  assign advance   = !(out_valid && out_stall);
  assign job_stall = !advance;

  data_t q1, q2;
  logic  c1, c2;
  bqp_divider u_div1 (.clk, .advance, .enable(job.div1), .num(job.num1),
                      .den(job.den1), .quotient(q1), .clipped(c1));
  bqp_divider u_div2 (.clk, .advance, .enable(job.div2), .num(job.num2),
                      .den(job.den2), .quotient(q2), .clipped(c2));

  // side info travels beside the dividers
  logic  sv  [Depth];
  job_t  sj  [Depth];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) sv[i] <= 1'b0;
    end else if (advance) begin
      sv[0] <= job_valid;
      for (int i = 1; i < Depth; i++) sv[i] <= sv[i-1];
    end
    if (advance) begin
      sj[0] <= job;
      for (int i = 1; i < Depth; i++) sj[i] <= sj[i-1];
    end
  end

  // output register
  job_t tail;
  assign tail = sj[Depth-1];
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= sv[Depth-1];
    if (advance) begin
      first_value  <= tail.div1 ? q1 : tail.fix1;
      second_value <= tail.div2 ? q2 : tail.fix2;
      case_code    <= tail.code;
      singular     <= tail.singular;
      saturated    <= (tail.div1 && c1) || (tail.div2 && c2);
    end
  end
endmodule

// ----- design/box_qp_two_by_two_solver.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_qp_two_by_two_solver
// Box-constrained symmetric 2x2 quadratic subproblem solver, Q16.16.
// ---------------------------------------------------------------------------
// One word per cycle unless a result is stalled; 4 front stages, then one stage
// per quotient bit of the two pipelined dividers (WideWidth stages), then the
// output register. The whole pipeline holds while a result waits stalled.
module box_qp_two_by_two_solver import bqp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  data_t       diag_first,
  input  data_t       diag_second,
  input  data_t       off_diag,
  input  data_t       rhs_first,
  input  data_t       rhs_second,
  output logic        out_valid,
  input  logic        out_stall,
  output data_t       first_value,
  output data_t       second_value,
  output logic [3:0]  case_code,
  output logic        singular,
  output logic        saturated
);
  data_t lower, upper;
  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      lower <= '0;
      upper <= data_t'(1) <<< FracBits;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_LOWER: lower <= pwdata;
        REG_UPPER: upper <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      REG_LOWER: prdata = lower;
      REG_UPPER: prdata = upper;
      default:   prdata = '0;
    endcase
  end

  logic job_valid, job_stall;
  job_t job;
  assign in_stall = job_stall;

  bqp_front u_front (.clk, .rst, .advance(!job_stall),
    .in_valid(in_valid),
    .a11_in(diag_first), .a22_in(diag_second), .a12_in(off_diag),
    .b1_in(rhs_first), .b2_in(rhs_second), .lower, .upper,
    .job_valid, .job);

  bqp_back u_back (.clk, .rst, .job_valid, .job, .job_stall,
    .out_valid, .out_stall, .first_value, .second_value,
    .case_code, .singular, .saturated);
endmodule

// ----- design/bqp_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqp_checker
// Port-level checks of the 2x2 box QP solver.
// ---------------------------------------------------------------------------
`include "box_qp_two_by_two_solver_assert.svh"
module bqp_checker import bqp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] case_code,
  input logic       singular,
  input logic       saturated,
  input logic [31:0] first_value
);
  // a singular result carries zero values and no flags
  `BQP_ASSERT_IMP(a_sing, out_valid && singular,
    case_code == 4'd0 && !saturated && first_value == '0)
  // case code stays in its range
  `BQP_ASSERT_IMP(a_code, out_valid, case_code <= 4'd9)
  // input stalls only when output is stalled
  `BQP_ASSERT_IMP(a_stall, in_stall, out_valid && out_stall)
  // stalled result holds
  `BQP_ASSERT_NEXT(a_hold, out_valid && out_stall,
    out_valid && $stable(first_value) && $stable(case_code))
endmodule

bind box_qp_two_by_two_solver bqp_checker u_bqp_checker (.clk, .rst, .in_stall,
  .out_valid, .out_stall, .case_code, .singular, .saturated, .first_value);

// ----- dv/box_qp_two_by_two_solver_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_qp_two_by_two_solver_tb
// Self-checking bench for the 2x2 box QP solver. A directed table, then random
// words under several box settings. Every accepted word is predicted with
// exact wide arithmetic, and each result is checked in order.
// ---------------------------------------------------------------------------
module box_qp_two_by_two_solver_tb;
  import bqp_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int Settle    = 140;   // covers front stages + divider pipe
  localparam int PerPhase  = 140;

  typedef logic signed [255:0] big_t;

  typedef struct packed {
    data_t x1;
    data_t x2;
    case_t code;
    logic  sing;
    logic  sat;
  } sol_t;

  typedef struct {
    data_t a11, a22, a12, b1, b2;
    logic  typed;
    sol_t  sol;
  } row_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  data_t diag_first, diag_second, off_diag, rhs_first, rhs_second;
  data_t first_value, second_value;
  logic [3:0] case_code;
  logic singular, saturated;

  data_t lower_cfg, upper_cfg;
  sol_t  pending_sols[$];
  sol_t  typed_sols[$];
  logic  typed_flags[$];
  int    errors, words_in, words_out, idle_cycles, sat_seen;
  logic  calm;

  box_qp_two_by_two_solver uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .diag_first, .diag_second, .off_diag, .rhs_first,
    .rhs_second, .out_valid, .out_stall, .first_value, .second_value,
    .case_code, .singular, .saturated
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // signed quotient truncated toward zero, clipped to data range
  function automatic data_t clip_quot(big_t n, big_t d, inout logic sat);
    big_t q;
    if (d == 0) return '0;
    q = n / d;
    if (q < -(big_t'(1) <<< 31)) begin
      sat = 1'b1;
      return data_t'(32'h8000_0000);
    end
    if (q > (big_t'(1) <<< 31) - 1) begin
      sat = 1'b1;
      return data_t'(32'h7fff_ffff);
    end
    return data_t'(q[31:0]);
  endfunction

  // exact solve of one subproblem under the current box
  function automatic sol_t solve_box(data_t i11, data_t i22, data_t i12,
                                     data_t ib1, data_t ib2);
    big_t a11, a22, a12, b1, b2, lo, hi, sc, det, m1, m2, bs1, bs2;
    big_t sl, su, tl, tu, p1ul, p1lu, p2ul, p2lu, dl, du;
    sol_t r;
    a11 = i11; a22 = i22; a12 = i12; b1 = ib1; b2 = ib2;
    lo = lower_cfg; hi = upper_cfg;
    sc = big_t'(1) <<< FracBits;
    det = a11 * a22 - a12 * a12;
    m1 = (a22 * b1 - a12 * b2) * sc;
    m2 = (a11 * b2 - a12 * b1) * sc;
    r = '{x1: '0, x2: '0, code: CASE_FREE, sing: 1'b0, sat: 1'b0};
    bs1 = b1 * sc; bs2 = b2 * sc;
    sl = (a11 + a12) * lo; su = (a11 + a12) * hi;
    tl = (a12 + a22) * lo; tu = (a12 + a22) * hi;
    p1ul = a11 * hi + a12 * lo; p1lu = a11 * lo + a12 * hi;
    p2ul = a12 * hi + a22 * lo; p2lu = a12 * lo + a22 * hi;
    dl = det * lo; du = det * hi;
    if (det == 0) begin
      r.sing = 1'b1;
    end else if (lo >= hi) begin
      r.x1 = clip_quot(m1, det, r.sat);
      r.x2 = clip_quot(m2, det, r.sat);
    end else if (bs1 <= sl && bs2 <= tl) begin
      r.code = CASE_LL; r.x1 = lower_cfg; r.x2 = lower_cfg;
    end else if (sl < bs1 && bs1 < p1ul && m2 <= dl) begin
      r.code = CASE_IL; r.x1 = clip_quot(bs1 - a12 * lo, a11, r.sat);
      r.x2 = lower_cfg;
    end else if (p1ul <= bs1 && bs2 <= p2ul) begin
      r.code = CASE_UL; r.x1 = upper_cfg; r.x2 = lower_cfg;
    end else if (bs1 <= p1lu && p2lu <= bs2) begin
      r.code = CASE_LU; r.x1 = lower_cfg; r.x2 = upper_cfg;
    end else if (su <= bs1 && tu <= bs2) begin
      r.code = CASE_UU; r.x1 = upper_cfg; r.x2 = upper_cfg;
    end else if (p1lu < bs1 && bs1 < su && du <= m2) begin
      r.code = CASE_IU; r.x1 = clip_quot(bs1 - a12 * hi, a11, r.sat);
      r.x2 = upper_cfg;
    end else if (tl < bs2 && bs2 < p2lu && m1 <= dl) begin
      r.code = CASE_LI; r.x1 = lower_cfg;
      r.x2 = clip_quot(bs2 - a12 * lo, a22, r.sat);
    end else if (p2ul < bs2 && bs2 < tu && du <= m1) begin
      r.code = CASE_UI; r.x1 = upper_cfg;
      r.x2 = clip_quot(bs2 - a12 * hi, a22, r.sat);
    end else begin
      r.code = CASE_II;
      r.x1 = clip_quot(m1, det, r.sat);
      r.x2 = clip_quot(m2, det, r.sat);
    end
    return r;
  endfunction

  // accept words, predict, check results, watchdog
  always @(posedge clk) begin
    sol_t want;
    sol_t typed;
    logic has_typed;
    if (!rst) begin
      idle_cycles = idle_cycles + 1;
      if (in_valid && !in_stall) begin
        pending_sols.push_back(solve_box(diag_first, diag_second, off_diag,
                                         rhs_first, rhs_second));
        words_in = words_in + 1;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        words_out = words_out + 1;
        if (saturated) sat_seen = sat_seen + 1;
        if (pending_sols.size() == 0) begin
          $display("%0t: result with nothing pending: %h %h %0d %b %b", $time,
                   first_value, second_value, case_code, singular, saturated);
          errors = errors + 1;
        end else begin
          want = pending_sols.pop_front();
          has_typed = typed_flags.pop_front();
          typed = typed_sols.pop_front();
          if (has_typed && typed != want) begin
            $display("%0t: table expects %h %h %0d %b %b, predictor %h %h %0d %b %b",
                     $time, typed.x1, typed.x2, typed.code, typed.sing, typed.sat,
                     want.x1, want.x2, want.code, want.sing, want.sat);
            errors = errors + 1;
          end
          if (first_value !== want.x1 || second_value !== want.x2 ||
              case_code !== want.code || singular !== want.sing ||
              saturated !== want.sat) begin
            $display("%0t: expected %h %h %0d %b %b, got %h %h %0d %b %b", $time,
                     want.x1, want.x2, want.code, want.sing, want.sat,
                     first_value, second_value, case_code, singular, saturated);
            errors = errors + 1;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("box_qp_two_by_two_solver: mismatch");
        $finish;
      end
    end
  end

  // result stall
  always @(negedge clk) out_stall <= rst ? 1'b0 : (!calm && $urandom_range(99) < 26);

  task automatic reg_write(logic [AddrWidth-1:0] addr, data_t value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_LOWER) lower_cfg = value;
    else upper_cfg = value;
  endtask

  // wait for the pipe to drain, then load a new box
  task automatic set_box(data_t lo, data_t hi);
    wait (pending_sols.size() == 0);
    repeat (Settle) @(negedge clk);
    reg_write(REG_LOWER, lo);
    reg_write(REG_UPPER, hi);
  endtask

  task automatic send_word(data_t a11, data_t a22, data_t a12, data_t b1,
                           data_t b2, logic typed, sol_t sol);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    diag_first <= a11; diag_second <= a22; off_diag <= a12;
    rhs_first <= b1; rhs_second <= b2;
    typed_flags.push_back(typed);
    typed_sols.push_back(sol);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    int kind, m, d1, d2;
    data_t a11, a22, a12, b1, b2;
    sol_t none;
    none = '{x1: '0, x2: '0, code: CASE_FREE, sing: 1'b0, sat: 1'b0};
    kind = $urandom_range(99);
    if (kind < 15) begin
      // raw noise over the full range
      a11 = $urandom; a22 = $urandom; a12 = $urandom; b1 = $urandom; b2 = $urandom;
    end else if (kind < 25) begin
      // rank-one matrix: zero determinant
      a11 = int'($urandom_range(0, 1 << 18)) - (1 << 17);
      a22 = a11; a12 = ($urandom_range(1)) ? a11 : -a11;
      b1 = $urandom; b2 = $urandom;
    end else if (kind < 35) begin
      // tiny entries, large rhs: quotients run out of range
      a11 = int'($urandom_range(0, 8)) - 4; a22 = int'($urandom_range(0, 8)) - 4;
      a12 = int'($urandom_range(0, 4)) - 2;
      b1 = $urandom; b2 = $urandom;
    end else begin
      // positive definite with moderate rhs
      d1 = $urandom_range(1 << 14, 1 << 18);
      d2 = $urandom_range(1 << 14, 1 << 18);
      m = ((d1 < d2) ? d1 : d2) - 1;
      a11 = d1; a22 = d2;
      a12 = int'($urandom_range(0, 2 * m)) - m;
      b1 = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      b2 = int'($urandom_range(0, 1 << 20)) - (1 << 19);
    end
    send_word(a11, a22, a12, b1, b2, 1'b0, none);
  endtask

  localparam data_t One = 32'h0001_0000;
  localparam data_t Half = 32'h0000_8000;
  localparam data_t MaxV = 32'h7fff_ffff;
  localparam data_t MinV = 32'h8000_0000;

  row_t rows[] = '{
    '{'0, '0, '0, '0, '0, 1'b1, '{'0, '0, CASE_FREE, 1'b1, 1'b0}},
    '{One, One, One, One, MinV, 1'b1, '{'0, '0, CASE_FREE, 1'b1, 1'b0}},
    '{One, One, '0, Half, Half, 1'b1, '{Half, Half, CASE_II, 1'b0, 1'b0}},
    '{One, One, '0, -One, -One, 1'b1, '{'0, '0, CASE_LL, 1'b0, 1'b0}},
    '{One, One, '0, 2 * One, 2 * One, 1'b1, '{One, One, CASE_UU, 1'b0, 1'b0}},
    '{One, One, '0, 2 * One, -One, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{One, One, '0, -One, 2 * One, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{One, One, '0, Half, -One, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{One, One, '0, Half, 2 * One, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{One, One, '0, -One, Half, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{One, One, '0, 2 * One, Half, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{2 * One, 2 * One, -One, One, One, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{MaxV, MaxV, MinV, MaxV, MinV, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{MinV, MinV, MaxV, MinV, MaxV, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{MaxV, MinV, '0, MaxV, MaxV, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{32'sd1, 32'sd1, '0, MaxV, MinV, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}},
    '{-32'sd1, -32'sd1, '0, -32'sd1, '1, 1'b0, '{'0, '0, CASE_FREE, 1'b0, 1'b0}}
  };

  data_t box_lo[6] = '{32'sd0, MinV, '0, -One, MaxV, -One};
  data_t box_hi[6] = '{One, MaxV, '0, One, MinV, 4 * One};

  // stimulus
  initial begin
    rst = 1'b1; calm = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; out_stall = 1'b0;
    diag_first = '0; diag_second = '0; off_diag = '0; rhs_first = '0; rhs_second = '0;
    lower_cfg = '0; upper_cfg = One;
    errors = 0; words_in = 0; words_out = 0; idle_cycles = 0; sat_seen = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset box first: directed table
    foreach (rows[i])
      send_word(rows[i].a11, rows[i].a22, rows[i].a12, rows[i].b1, rows[i].b2,
                rows[i].typed, rows[i].sol);
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        set_box(box_lo[p], box_hi[p]);
      end
      calm = (p == 3);
      for (int k = 0; k < PerPhase; k++) send_random();
    end
    @(negedge clk);
    in_valid <= 1'b0;
    calm = 1'b0;
    wait (pending_sols.size() == 0);
    repeat (Settle) @(posedge clk);

    $display("%0d words in, %0d results, %0d saturated, over six box settings",
             words_in, words_out, sat_seen);
    if (errors == 0 && pending_sols.size() == 0)
      $display("box_qp_two_by_two_solver: match");
    else
      $display("box_qp_two_by_two_solver: mismatch");
    $finish;
  end
endmodule
